@@ sv/tdk_pkg.sv @@
// shared types and constants for the two-key debouncer with combo detection
// no dependencies; imported by every module of the block

package tdk_pkg;

    // event bits of the latched event word
    localparam logic [2:0] EV_UP   = 3'b001;
    localparam logic [2:0] EV_DOWN = 3'b010;
    localparam logic [2:0] EV_BOTH = 3'b100;

    // register indexes (word address bit 2)
    localparam logic REG_PRESS = 1'b0;
    localparam logic REG_HELD  = 1'b1;

    // register reset values
    localparam logic [2:0] PRESS_RST = 3'd5;
    localparam logic [3:0] HELD_RST  = 4'd10;

    // stream and APB widths
    localparam int TDATA_W = 8;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // debounce thresholds as seen by the key counters
    typedef struct packed {
        logic [2:0] press_count;
        logic [3:0] held_count;
    } key_cfg_t;

    // one key counter update
    typedef struct packed {
        logic [3:0] count;
        logic [2:0] events;
    } key_upd_t;

endpackage

@@ sv/tdk_cfg.sv @@
// configuration registers behind an APB-style port
// depends on tdk_pkg for register indexes, reset values and key_cfg_t

module tdk_cfg
    import tdk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output key_cfg_t          cfg
);

    logic [2:0] press_reg;
    logic [3:0] held_reg;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    // register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_reg <= PRESS_RST;
            held_reg  <= HELD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PRESS: press_reg <= pwdata[2:0];
                REG_HELD:  held_reg  <= pwdata[3:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_PRESS: prdata = {{(APB_DW-3){1'b0}}, press_reg};
            REG_HELD:  prdata = {{(APB_DW-4){1'b0}}, held_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.press_count = press_reg;
    assign cfg.held_count  = held_reg;

endmodule

@@ sv/tdk_key.sv @@
// next-state logic of one key counter and the event it raises
// depends on tdk_pkg for key_cfg_t, key_upd_t and event codes

module tdk_key
    import tdk_pkg::*;
(
    input  key_cfg_t   cfg,
    input  logic       pressed,
    input  logic [3:0] count,
    input  logic       other_pressed,
    input  logic [3:0] other_count,
    input  logic [2:0] own_event,
    output key_upd_t   upd
);

    logic [3:0] press_ext;
    logic [3:0] inc;
    logic [3:0] dec;

    assign press_ext = {1'b0, cfg.press_count};
    assign inc       = count + 4'd1;
    assign dec       = count - 4'd1;

    // count up while pressed, count down and snap to zero on release
    always_comb
    begin
        upd.count  = count;
        upd.events = 3'b000;
        if (pressed)
        begin
            if (count < press_ext)
            begin
                upd.count = inc;
                if (inc >= press_ext)
                begin
                    upd.count = cfg.held_count;
                    if (other_pressed && (other_count >= cfg.held_count))
                        upd.events = EV_BOTH;
                    else
                        upd.events = own_event;
                end
            end
        end
        else if (count != 4'd0)
        begin
            upd.count = (dec <= press_ext) ? 4'd0 : dec;
        end
    end

endmodule

@@ sv/two_key_debounce_with_combo.sv @@
// top level of the two-key debouncer with combo detection
// depends on tdk_pkg, tdk_cfg and tdk_key
//
// Usage:
//   Slave stream s_axis_*: one request per tick or read. tuser is the mode
//   (0 = tick sampling the pins, 1 = read and clear the latched events).
//   tdata carries the raw active-low pins.
//   Master stream m_axis_*: exactly one result per request. tdata[2:0] holds
//   the events latched before a read (bit0 up, bit1 down, bit2 both keys);
//   a tick returns zero.
//   APB port: press_count at 0x0, held_count at 0x4; write only while idle.
// Result path and throughput:
//   a result is registered in the result register, or in the skid register
//   while one waits; one request per cycle while s_axis_tready is high, since
//   the counters and event latch are combinational ahead of the result register.
// Reset:
//   counters and latched events clear, registers return to 5 and 10.
// Stall:
//   a two-entry output (result register plus skid register) keeps taking
//   requests while one result waits; s_axis_tready drops only when both hold.

module two_key_debounce_with_combo
    import tdk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // slave stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [0] up_pin, [1] down_pin, rest zero
    input  logic               s_axis_tuser,   // [0] mode
    // master stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [2:0] key_events, rest zero
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    key_cfg_t   cfg;
    key_upd_t   up_upd;
    key_upd_t   down_upd;

    logic [3:0] up_count_reg;
    logic [3:0] down_count_reg;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic [2:0] result_next;

    logic       out_valid_reg;
    logic [2:0] out_data_reg;
    logic       skid_valid_reg;
    logic [2:0] skid_data_reg;

    logic       accept;
    logic       pop;
    logic       is_read;
    logic       up_pressed;
    logic       down_pressed;

    tdk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign is_read      = s_axis_tuser;
    assign up_pressed   = ~s_axis_tdata[0];
    assign down_pressed = ~s_axis_tdata[1];

    // up key goes first
    tdk_key u_up (
        .cfg           (cfg),
        .pressed       (up_pressed),
        .count         (up_count_reg),
        .other_pressed (down_pressed),
        .other_count   (down_count_reg),
        .own_event     (EV_UP),
        .upd           (up_upd)
    );

    // down key sees the updated up counter
    tdk_key u_down (
        .cfg           (cfg),
        .pressed       (down_pressed),
        .count         (down_count_reg),
        .other_pressed (up_pressed),
        .other_count   (up_upd.count),
        .own_event     (EV_DOWN),
        .upd           (down_upd)
    );

    assign accept = s_axis_tvalid & s_axis_tready;
    assign pop    = m_axis_tvalid & m_axis_tready;

    // event latch and result value
    always_comb
    begin
        if (is_read)
        begin
            pending_next = 3'b000;
            result_next  = pending_reg;
        end
        else
        begin
            pending_next = pending_reg | up_upd.events | down_upd.events;
            result_next  = 3'b000;
        end
    end

    // key counters and pending events
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_count_reg   <= 4'd0;
            down_count_reg <= 4'd0;
            pending_reg    <= 3'b000;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            if (!is_read)
            begin
                up_count_reg   <= up_upd.count;
                down_count_reg <= down_upd.count;
            end
        end
    end

    // result register with skid register behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result_next;
        end
        if (accept && out_valid_reg && !pop)
        begin
            skid_data_reg <= result_next;
        end
    end

    assign s_axis_tready = ~skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W-3){1'b0}}, out_data_reg};

endmodule

@@ sv/tdk_checker.sv @@
// port-level checks for the two-key debouncer with combo detection
// depends on tdk_pkg; bound to the top level at the end of this file

module tdk_checker
    import tdk_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    // an accepted request always leaves a result pending next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request left no result");

    // input back-pressure only while a result is already waiting
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // result padding bits stay zero
    a_result_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1:3] == '0))
        else $error("nonzero padding in result");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

endmodule

bind two_key_debounce_with_combo tdk_checker u_tdk_checker (.*);

@@ tb/tb_top.sv @@
// testbench for the two-key debouncer with combo detection: a directed table, then
// random key bursts across several threshold settings, checked against a local predictor
// depends on tdk_pkg and two_key_debounce_with_combo
`timescale 1ns / 100ps

module tb_top;
    import tdk_pkg::*;

    localparam int RAND_PER_SETTING = 173;
    localparam int IDLE_PCT         = 26;
    localparam int STALL_AFTER      = 450;
    localparam int STALL_CYCLES     = 100;
    localparam logic [APB_AW-1:0] ADDR_PRESS = {REG_PRESS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_HELD  = {REG_HELD, 2'b00};
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // one row of the directed table; ev is used only where typed is set
    typedef struct packed {
        logic       mode;
        logic       up_pin;
        logic       down_pin;
        logic       typed;
        logic [2:0] ev;
    } key_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;    // [0] up_pin, [1] down_pin, rest zero
    logic               s_axis_tuser;    // [0] mode
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;    // [2:0] key_events, rest zero
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // predictor state
    logic [2:0] thr_press;
    logic [3:0] thr_held;
    logic [3:0] up_cnt;
    logic [3:0] dn_cnt;
    logic [2:0] latched_ev;

    logic [2:0] events_due[$];
    int         n_errors;
    int         n_requests;
    int         n_reads;
    int         n_combo;
    int         n_results;
    int         n_settings;
    bit         calm;

    key_row_t key_rows [0:24];

    two_key_debounce_with_combo u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [APB_DW-1:0] got,
                                 input logic [APB_DW-1:0] want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // one key counter step; latches the key's own event or the combo event
    function automatic logic [3:0] key_next(input logic pressed, input logic [3:0] cnt,
                                            input logic other_pressed,
                                            input logic [3:0] other_cnt,
                                            input logic [2:0] own_ev);
        logic [3:0] nxt;
        nxt = cnt;
        if (pressed)
        begin
            if (cnt < thr_press)
            begin
                nxt = cnt + 4'd1;
                if (nxt >= thr_press)
                begin
                    if (other_pressed && other_cnt >= thr_held)
                        latched_ev = latched_ev | EV_BOTH;
                    else
                        latched_ev = latched_ev | own_ev;
                    nxt = thr_held;
                end
            end
        end
        else if (cnt != 4'd0)
        begin
            nxt = cnt - 4'd1;
            if (nxt <= thr_press)
                nxt = 4'd0;
        end
        return nxt;
    endfunction

    // expected key_events for one request; up key first, down sees the new up count
    function automatic logic [2:0] debounce_model(input logic mode, input logic up_pin,
                                                  input logic down_pin);
        logic [2:0] ev;
        ev = 3'd0;
        if (mode == MODE_READ)
        begin
            ev = latched_ev;
            latched_ev = 3'd0;
        end
        else
        begin
            up_cnt = key_next(!up_pin, up_cnt, !down_pin, dn_cnt, EV_UP);
            dn_cnt = key_next(!down_pin, dn_cnt, !up_pin, up_cnt, EV_DOWN);
        end
        return ev;
    endfunction

    // offer one request, with random gaps unless calm
    task automatic send_request(input logic mode, input logic up_pin, input logic down_pin,
                                input logic typed, input logic [2:0] typed_ev);
        logic [2:0] ev;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(TDATA_W-2){1'b0}}, down_pin, up_pin};
        do
            @(posedge clk);
        while (!s_axis_tready);
        ev = debounce_model(mode, up_pin, down_pin);
        if (typed)
            ev = typed_ev;
        events_due.push_back(ev);
        n_requests++;
        if (mode == MODE_READ)
            n_reads++;
        if (ev[2])
            n_combo++;
    endtask

    // setup and access phases, then back to idle
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write both thresholds and read them back
    task automatic set_thresholds(input logic [2:0] press, input logic [3:0] held);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, ADDR_PRESS, {{(APB_DW-3){1'b0}}, press}, rd);
        thr_press = press;
        apb_access(1'b1, ADDR_HELD, {{(APB_DW-4){1'b0}}, held}, rd);
        thr_held = held;
        apb_access(1'b0, ADDR_PRESS, '0, rd);
        if (rd !== {{(APB_DW-3){1'b0}}, press})
            flag_mismatch("press_count readback", rd, {{(APB_DW-3){1'b0}}, press});
        apb_access(1'b0, ADDR_HELD, '0, rd);
        if (rd !== {{(APB_DW-4){1'b0}}, held})
            flag_mismatch("held_count readback", rd, {{(APB_DW-4){1'b0}}, held});
        n_settings++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
    endtask

    // result side: check each result, random backpressure, one long hold-off
    initial
    begin
        int  hold_left;
        bit  hold_done;
        logic [2:0] want;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (events_due.size() == 0)
                    flag_mismatch("result with no request outstanding",
                                  APB_DW'(m_axis_tdata), '0);
                else
                begin
                    want = events_due.pop_front();
                    if (m_axis_tdata[2:0] !== want)
                        flag_mismatch("key_events", APB_DW'(m_axis_tdata[2:0]),
                                      APB_DW'(want));
                end
            end
            if (n_results >= STALL_AFTER && !hold_done)
            begin
                hold_left = STALL_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (!calm && $urandom_range(0, 99) < IDLE_PCT)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        logic [2:0]        press_set [0:9];
        logic [3:0]        held_set [0:9];
        logic [APB_DW-1:0] rd;
        int  burst_left;
        bit  burst_up;
        bit  burst_dn;
        logic up_pin;
        logic down_pin;

        // directed table: reads after reset, pins ignored on a read, both keys
        // (up then combo), release, up alone, down alone
        key_rows[0]  = '{MODE_READ, 1'b1, 1'b1, 1'b1, 3'd0};
        key_rows[1]  = '{MODE_READ, 1'b0, 1'b0, 1'b1, 3'd0};
        for (int i = 2; i < 7; i++)
            key_rows[i] = '{MODE_TICK, 1'b0, 1'b0, 1'b1, 3'd0};
        key_rows[7]  = '{MODE_READ, 1'b1, 1'b1, 1'b0, 3'd0};
        for (int i = 8; i < 13; i++)
            key_rows[i] = '{MODE_TICK, 1'b1, 1'b1, 1'b1, 3'd0};
        for (int i = 13; i < 18; i++)
            key_rows[i] = '{MODE_TICK, 1'b0, 1'b1, 1'b1, 3'd0};
        key_rows[18] = '{MODE_READ, 1'b1, 1'b1, 1'b0, 3'd0};
        for (int i = 19; i < 24; i++)
            key_rows[i] = '{MODE_TICK, 1'b1, 1'b0, 1'b1, 3'd0};
        key_rows[24] = '{MODE_READ, 1'b1, 1'b1, 1'b0, 3'd0};

        // threshold settings: extremes, zero press count, held below press
        press_set = '{3'd1, 3'd7, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd6, 3'd1, 3'd5};
        held_set  = '{4'd8, 4'd15, 4'd10, 4'd3, 4'd0, 4'd12, 4'd9, 4'd14, 4'd8, 4'd10};
        press_set[8] = 3'($urandom_range(1, 7));
        held_set[8]  = 4'($urandom_range(8, 15));

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '1;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        n_errors      = 0;
        n_requests    = 0;
        n_reads       = 0;
        n_combo       = 0;
        n_results     = 0;
        n_settings    = 0;
        calm          = 1'b0;
        thr_press     = PRESS_RST;
        thr_held      = HELD_RST;
        up_cnt        = 4'd0;
        dn_cnt        = 4'd0;
        latched_ev    = 3'd0;

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        apb_access(1'b0, ADDR_PRESS, '0, rd);
        if (rd !== {{(APB_DW-3){1'b0}}, PRESS_RST})
            flag_mismatch("press_count after reset", rd, {{(APB_DW-3){1'b0}}, PRESS_RST});
        apb_access(1'b0, ADDR_HELD, '0, rd);
        if (rd !== {{(APB_DW-4){1'b0}}, HELD_RST})
            flag_mismatch("held_count after reset", rd, {{(APB_DW-4){1'b0}}, HELD_RST});

        // directed part
        foreach (key_rows[i])
            send_request(key_rows[i].mode, key_rows[i].up_pin, key_rows[i].down_pin,
                         key_rows[i].typed, key_rows[i].ev);
        drain_results();

        // random key bursts per setting, with reads and pin chatter
        burst_left = 0;
        burst_up   = 1'b0;
        burst_dn   = 1'b0;
        for (int s = 0; s < 10; s++)
        begin
            set_thresholds(press_set[s], held_set[s]);
            calm = (s == 5);
            for (int n = 0; n < RAND_PER_SETTING; n++)
            begin
                // sender pause until everything has come back
                if (s == 4 && n == RAND_PER_SETTING / 2)
                    drain_results();
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    burst_up   = 1'($urandom_range(0, 1));
                    burst_dn   = 1'($urandom_range(0, 1));
                end
                burst_left--;
                up_pin   = !burst_up;
                down_pin = !burst_dn;
                if ($urandom_range(0, 99) < 6)
                    up_pin = !up_pin;
                if ($urandom_range(0, 99) < 6)
                    down_pin = !down_pin;
                if ($urandom_range(0, 99) < 15)
                    send_request(MODE_READ, 1'($urandom), 1'($urandom), 1'b0, 3'd0);
                else
                    send_request(MODE_TICK, up_pin, down_pin, 1'b0, 3'd0);
            end
            drain_results();
        end
        calm = 1'b0;

        repeat (5) @(posedge clk);
        $display("ran %0d requests (%0d reads, %0d combo events expected) over %0d settings",
                 n_requests, n_reads, n_combo, n_settings);
        $display("including backpressure hold-off, sender pause and a gap-free stretch");
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
